// ===== sv/desk_frame_height_decoder_defines.svh =====
// Assertion macros shared by the desk frame height decoder RTL.
// No dependencies; included by the top level only.
`ifndef DESK_FRAME_HEIGHT_DECODER_DEFINES_SVH
`define DESK_FRAME_HEIGHT_DECODER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define DFH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfh assertion failed");

// Condition that must never be true outside reset.
`define DFH_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dfh assertion failed");

`endif

// ===== sv/dfh_pkg.sv =====
// Shared types, constants and the seven-segment digit table for the
// desk frame height decoder. No dependencies.
package dfh_pkg;

    localparam logic [7:0] SYNC_BYTE       = 8'h5a;
    localparam int         DP_BIT          = 7;
    localparam logic [7:0] SEG_MASK        = 8'h7f;
    localparam logic [2:0] FRAME_LEN_RESET = 3'd5;
    localparam logic [2:0] FRAME_LEN_SIX   = 3'd6;
    localparam logic [2:0] BODY_LEN_FIVE   = 3'd4;
    localparam logic [2:0] BODY_LEN_SIX    = 3'd5;
    localparam logic [7:0] TYPE_HEIGHT     = 8'h01;
    localparam logic [3:0] DIGIT_BAD       = 4'd10;
    localparam int         HEIGHT_W        = 14;

    typedef enum logic [2:0] {
        ST_VALID     = 3'd0,
        ST_CHECKSUM  = 3'd1,
        ST_TYPE      = 3'd2,
        ST_BLANK     = 3'd3,
        ST_BAD_DIGIT = 3'd4
    } t_status;

    typedef struct packed {
        logic       six;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] chk;
    } t_frame;

    function automatic logic [3:0] seg_digit(input logic [7:0] pattern);
        logic [3:0] d;
        unique case (pattern & SEG_MASK)
            8'h3f:   d = 4'd0;
            8'h06:   d = 4'd1;
            8'h5b:   d = 4'd2;
            8'h4f:   d = 4'd3;
            8'h67:   d = 4'd4;
            8'h6d:   d = 4'd5;
            8'h7d:   d = 4'd6;
            8'h07:   d = 4'd7;
            8'h7f:   d = 4'd8;
            8'h6f:   d = 4'd9;
            default: d = DIGIT_BAD;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/dfh_frame.sv =====
// Sync hunt and byte collection; registers each completed frame.
// Depends on dfh_pkg.
module dfh_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_six,
    input  logic            i_rx_valid,
    output logic            o_rx_ready,
    input  logic [7:0]      i_rx_byte,
    output logic            o_frm_valid,
    input  logic            i_frm_take,
    output dfh_pkg::t_frame o_frm
);

    logic            r_in_frame;
    logic [2:0]      r_count;
    logic [7:0]      r_bytes [5];
    logic            r_frm_valid;
    dfh_pkg::t_frame r_frm;

    logic [2:0]      n_count;
    logic [2:0]      need;
    logic            acc;
    logic            done;
    logic [7:0]      merged [5];
    dfh_pkg::t_frame n_frm;

    assign acc     = i_rx_valid && o_rx_ready;
    assign n_count = r_count + 3'd1;
    assign need    = i_six ? dfh_pkg::BODY_LEN_SIX : dfh_pkg::BODY_LEN_FIVE;
    assign done    = r_in_frame && (n_count >= need);

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            merged[k] = (r_count == 3'(k)) ? i_rx_byte : r_bytes[k];
        end
        n_frm.six = i_six;
        n_frm.b0  = merged[0];
        n_frm.b1  = merged[1];
        n_frm.b2  = merged[2];
        n_frm.b3  = merged[3];
        n_frm.chk = i_six ? merged[4] : merged[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_count     <= 3'd0;
            r_frm_valid <= 1'b0;
        end else begin
            if (acc) begin
                if (!r_in_frame) begin
                    if (i_rx_byte == dfh_pkg::SYNC_BYTE) begin
                        r_in_frame <= 1'b1;
                        r_count    <= 3'd0;
                    end
                end else if (done) begin
                    r_in_frame <= 1'b0;
                    r_count    <= 3'd0;
                end else begin
                    r_count <= n_count;
                end
            end
            if (acc && done) begin
                r_frm_valid <= 1'b1;
            end else if (i_frm_take) begin
                r_frm_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && r_in_frame && (r_count < 3'd5)) begin
            r_bytes[r_count] <= i_rx_byte;
        end
        if (acc && done) begin
            r_frm <= n_frm;
        end
    end

    assign o_rx_ready  = !r_frm_valid || i_frm_take;
    assign o_frm_valid = r_frm_valid;
    assign o_frm       = r_frm;

endmodule

// ===== sv/dfh_decode.sv =====
// Frame checks, digit decode and height change tracking; result register.
// Depends on dfh_pkg.
module dfh_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_frm_valid,
    input  dfh_pkg::t_frame              i_frm,
    output logic                         o_frm_take,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [2:0]                   o_frame_status,
    output logic [dfh_pkg::HEIGHT_W-1:0] o_height_tenths,
    output logic                         o_height_changed
);

    logic                         r_res_valid;
    dfh_pkg::t_status             r_status;
    logic [dfh_pkg::HEIGHT_W-1:0] r_height;
    logic                         r_changed;
    logic [dfh_pkg::HEIGHT_W-1:0] r_last;

    logic [7:0]                   sum;
    logic [3:0]                   d0;
    logic [3:0]                   d1;
    logic [3:0]                   d2;
    logic [9:0]                   value;
    logic [dfh_pkg::HEIGHT_W-1:0] height;
    dfh_pkg::t_status             n_status;
    logic [dfh_pkg::HEIGHT_W-1:0] n_height;
    logic                         n_changed;

    assign o_frm_take = i_frm_valid && (!r_res_valid || i_res_ready);

    always_comb begin
        sum = i_frm.b0 + i_frm.b1 + i_frm.b2 + (i_frm.six ? i_frm.b3 : 8'd0);
        d0  = dfh_pkg::seg_digit(i_frm.b0);
        d1  = dfh_pkg::seg_digit(i_frm.b1);
        d2  = dfh_pkg::seg_digit(i_frm.b2);
        value = ({6'd0, d0} * 10'd100) + ({6'd0, d1} * 10'd10) + {6'd0, d2};
        if (i_frm.b1[dfh_pkg::DP_BIT]) begin
            height = {4'd0, value};
        end else begin
            height = {4'd0, value} * 14'd10;
        end
        n_height  = '0;
        n_changed = 1'b0;
        if (sum != i_frm.chk) begin
            n_status = dfh_pkg::ST_CHECKSUM;
        end else if (i_frm.six && (i_frm.b3 != dfh_pkg::TYPE_HEIGHT)) begin
            n_status = dfh_pkg::ST_TYPE;
        end else if ((i_frm.b0 | i_frm.b1 | i_frm.b2) == 8'd0) begin
            n_status = dfh_pkg::ST_BLANK;
        end else if ((d0 > 4'd9) || (d1 > 4'd9) || (d2 > 4'd9)) begin
            n_status = dfh_pkg::ST_BAD_DIGIT;
        end else begin
            n_status  = dfh_pkg::ST_VALID;
            n_height  = height;
            n_changed = (height != r_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            if (o_frm_take) begin
                r_res_valid <= 1'b1;
                if (n_status == dfh_pkg::ST_VALID) begin
                    r_last <= n_height;
                end
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frm_take) begin
            r_status  <= n_status;
            r_height  <= n_height;
            r_changed <= n_changed;
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_frame_status   = r_status;
    assign o_height_tenths  = r_height;
    assign o_height_changed = r_changed;

endmodule

// ===== sv/desk_frame_height_decoder.sv =====
// Desk frame height decoder top level: config register, framer, decoder.
// Depends on dfh_pkg, dfh_frame, dfh_decode and the defines header.
//
// Usage:
//   Receive channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one serial
//   byte per transaction. Outside a frame, bytes other than 0x5a are dropped.
//   After sync, 4 or 5 body bytes (frame length 5 or 6) complete a frame.
//   Result channel (o_res_valid / i_res_ready) carries one transaction per
//   completed frame: status, height in tenths, and the change flag.
//   i_cfg_we writes i_cfg_wdata to the frame length register; lengths of 6
//   or more act as 6, all others as 5. Write only while idle.
//   Throughput: one byte per cycle while o_rx_ready is high, set by the
//   single-pass decode between the frame register and the result register.
//   Path: the final byte of a frame is captured in the frame register, then
//   decoded into the result register; a held result not yet taken delays this.
//   Stall: while a result is held, bytes keep flowing until the next frame
//   completes into the frame register; o_rx_ready then stays low until the
//   held result is taken. Reset: sync hunt, frame length 5, last height 0.
`include "desk_frame_height_decoder_defines.svh"

module desk_frame_height_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_frame_status,
    output logic [13:0] o_height_tenths,
    output logic        o_height_changed
);

    logic [2:0]      r_frame_length;
    logic            six;
    logic            frm_valid;
    logic            frm_take;
    dfh_pkg::t_frame frm;
    logic            res_error;
    logic            res_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= dfh_pkg::FRAME_LEN_RESET;
        end else if (i_cfg_we) begin
            r_frame_length <= i_cfg_wdata;
        end
    end

    assign six = (r_frame_length >= dfh_pkg::FRAME_LEN_SIX);

    dfh_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_six       (six),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_frm_valid (frm_valid),
        .i_frm_take  (frm_take),
        .o_frm       (frm)
    );

    dfh_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_frm_valid      (frm_valid),
        .i_frm            (frm),
        .o_frm_take       (frm_take),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_frame_status   (o_frame_status),
        .o_height_tenths  (o_height_tenths),
        .o_height_changed (o_height_changed)
    );

    assign res_error = o_res_valid && (o_frame_status != dfh_pkg::ST_VALID);
    assign res_clear = (o_height_tenths == 14'd0) && !o_height_changed;

    `DFH_ASSERT_IMPL(a_error_zero, i_clk, i_rst_n, res_error, res_clear)
    `DFH_ASSERT_NEVER(a_status_range, i_clk, i_rst_n, o_res_valid && (o_frame_status > dfh_pkg::ST_BAD_DIGIT))
    `DFH_ASSERT_NEVER(a_height_range, i_clk, i_rst_n, o_res_valid && (o_height_tenths > 14'd9990))

endmodule
